[sv/spc_pkg.sv]
package spc_pkg;

  localparam int IDLE_TICKS     = 2000;
  localparam int INTEGRAL_LIMIT = 10000;
  localparam int TRIM_MAX       = 4094;
  localparam int COMPARE_MAX    = 4095;
  localparam int DRIFT_LIMIT    = 3;

  localparam int IDLE_W      = $clog2(IDLE_TICKS + 1);
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PID_W       = 36;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P           = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I           = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSE_LIMIT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_DIRECTION = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FOLLOW_LIMIT     = 3'd5;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [7:0]  sense_limit;
    logic        invert_direction;
    logic [7:0]  follow_limit;
  } cfg_t;

  // status that rides along with an item through the back part
  typedef struct packed {
    logic [11:0] trim;
    logic        fault;
    logic        power;
    logic        idle;
  } flags_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] deriv;
    logic signed [14:0] integral;
    flags_t             flags;
  } job_t;

endpackage

[sv/spc_ifs.sv]
interface spc_cmd_if;
  logic        valid;
  logic        ready;
  logic [15:0] position_error;
  logic [11:0] current_sample;
  logic        driver_fault_n;
  logic        overcurrent_n;
  logic        reset_n;

  modport source (output valid, position_error, current_sample, driver_fault_n,
                  overcurrent_n, reset_n, input ready);
  modport sink (input valid, position_error, current_sample, driver_fault_n,
                overcurrent_n, reset_n, output ready);
endinterface

interface spc_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] pwm_compare;
  logic        direction;
  logic        fault_flag;
  logic        power_ok;
  logic        motor_idle;

  modport source (output valid, pwm_compare, direction, fault_flag, power_ok,
                  motor_idle, input ready);
  modport sink (input valid, pwm_compare, direction, fault_flag, power_ok,
                motor_idle, output ready);
endinterface

[sv/spc_front.sv]
module spc_front (
  input  logic          clk,
  input  logic          rst,
  input  spc_pkg::cfg_t cfg,
  spc_cmd_if.sink       cmd,
  input  logic          q_full,
  output logic          push,
  output spc_pkg::job_t job
);

  localparam logic signed [16:0] ISUM_MAX  = 17'(spc_pkg::INTEGRAL_LIMIT);
  localparam logic signed [16:0] ISUM_MIN  = -17'(spc_pkg::INTEGRAL_LIMIT);
  localparam logic signed [16:0] DRIFT_MAX = 17'(spc_pkg::DRIFT_LIMIT);
  localparam logic signed [16:0] DRIFT_MIN = -17'(spc_pkg::DRIFT_LIMIT);
  localparam logic signed [13:0] TRIM_TOP  = 14'(spc_pkg::TRIM_MAX);

  logic signed [15:0]          last_error;
  logic signed [14:0]          integral_sum;
  logic [11:0]                 current_trim;
  logic                        fault_latch;
  logic                        power_latch;
  logic [spc_pkg::IDLE_W-1:0]  idle_count;
  logic                        idle_armed;
  logic                        idle_flag;
  logic signed [15:0]          error_at_idle;

  logic                        fault_next;
  logic                        power_next;
  logic [spc_pkg::IDLE_W-1:0]  idle_count_next;
  logic                        idle_armed_next;
  logic                        idle_flag_next;
  logic signed [15:0]          error_at_idle_next;
  logic [11:0]                 trim_next;
  logic signed [14:0]          integral_next;

  logic signed [16:0] err17;
  logic signed [16:0] last17;
  logic signed [16:0] lim17;
  logic signed [16:0] drift;
  logic               overrun;
  logic signed [12:0] trim_delta;
  logic signed [12:0] trim_step;
  logic signed [13:0] trim_sum;
  logic signed [16:0] isum;

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && !q_full;

  always_comb begin
    err17   = {cmd.position_error[15], cmd.position_error};
    last17  = {last_error[15], last_error};
    lim17   = {9'd0, cfg.follow_limit};
    overrun = (last17 > lim17) || (last17 < -lim17);

    fault_next         = fault_latch;
    power_next         = power_latch;
    idle_count_next    = idle_count;
    idle_armed_next    = idle_armed;
    idle_flag_next     = idle_flag;
    error_at_idle_next = error_at_idle;
    drift              = '0;

    // following-error test and idle timeout both look at the previous error
    priority if (overrun) begin
      fault_next = 1'b1;
    end else if (idle_count < spc_pkg::IDLE_W'(spc_pkg::IDLE_TICKS)) begin
      idle_count_next = idle_count + 1'b1;
      idle_armed_next = 1'b0;
      idle_flag_next  = 1'b0;
    end else begin
      if (!idle_armed) begin
        error_at_idle_next = last_error;
        idle_armed_next    = 1'b1;
        idle_flag_next     = 1'b1;
      end
      drift = {error_at_idle_next[15], error_at_idle_next} - last17;
      if (drift > DRIFT_MAX || drift < DRIFT_MIN) begin
        idle_count_next = '0;
      end
    end

    if (!cmd.driver_fault_n || !cmd.overcurrent_n) begin
      fault_next = 1'b1;
      power_next = 1'b0;
    end
    if (!cmd.reset_n) begin
      fault_next = 1'b1;
    end

    // current limiter: sample/2 millivolts against limit*4, step floored by 8
    trim_delta = $signed({2'b00, cmd.current_sample[11:1]})
               - $signed({3'b000, cfg.sense_limit, 2'b00});
    trim_step  = trim_delta >>> 3;
    trim_sum   = $signed({2'b00, current_trim}) + {trim_step[12], trim_step};
    if (trim_sum > TRIM_TOP) begin
      trim_next = 12'(spc_pkg::TRIM_MAX);
    end else if (trim_sum < 0) begin
      trim_next = '0;
    end else begin
      trim_next = trim_sum[11:0];
    end

    isum = {{2{integral_sum[14]}}, integral_sum} + (idle_flag_next ? 17'sd0 : err17);
    if (isum > ISUM_MAX) begin
      integral_next = ISUM_MAX[14:0];
    end else if (isum < ISUM_MIN) begin
      integral_next = ISUM_MIN[14:0];
    end else begin
      integral_next = isum[14:0];
    end

    job.err         = cmd.position_error;
    job.deriv       = err17 - last17;
    job.integral    = integral_next;
    job.flags.trim  = trim_next;
    job.flags.fault = fault_next;
    job.flags.power = power_next;
    job.flags.idle  = idle_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error    <= '0;
      integral_sum  <= '0;
      current_trim  <= '0;
      fault_latch   <= 1'b0;
      power_latch   <= 1'b1;
      idle_count    <= '0;
      idle_armed    <= 1'b0;
      idle_flag     <= 1'b0;
      error_at_idle <= '0;
    end else if (push) begin
      last_error    <= cmd.position_error;
      integral_sum  <= integral_next;
      current_trim  <= trim_next;
      fault_latch   <= fault_next;
      power_latch   <= power_next;
      idle_count    <= idle_count_next;
      idle_armed    <= idle_armed_next;
      idle_flag     <= idle_flag_next;
      error_at_idle <= error_at_idle_next;
    end
  end

endmodule

[sv/spc_queue.sv]
module spc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output spc_pkg::job_t q_job
);

  spc_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/spc_back.sv]
module spc_back (
  input  logic          clk,
  input  logic          rst,
  input  spc_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  spc_pkg::job_t q_job,
  output logic          pop,
  spc_res_if.source     res
);

  // stage 1: the three gain products
  logic                 v1;
  logic signed [32:0]   p_term;
  logic signed [31:0]   i_term;
  logic signed [33:0]   d_term;
  spc_pkg::flags_t      flags1;

  // stage 2: summed pid output
  logic                        v2;
  logic signed [spc_pkg::PID_W-1:0] pid;
  spc_pkg::flags_t             flags2;

  logic                 phase_bit;
  logic                 adv1;
  logic                 adv2;
  logic                 adv3;

  logic signed [32:0]   p_prod;
  logic signed [31:0]   i_prod;
  logic signed [33:0]   d_prod;

  logic                 neg;
  logic [spc_pkg::PID_W-1:0] abs_pid;
  logic [27:0]          mag_sh;
  logic [11:0]          mag_clamped;
  logic signed [12:0]   mag_trim;
  logic [11:0]          cmp;
  logic                 dir;

  assign adv3 = !res.valid || res.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pop  = q_valid && adv1;

  assign p_prod = 33'($signed({1'b0, cfg.gain_p})) * 33'(q_job.err);
  assign i_prod = 32'($signed({1'b0, cfg.gain_i})) * 32'(q_job.integral);
  assign d_prod = 34'($signed({1'b0, cfg.gain_d})) * 34'(q_job.deriv);

  always_comb begin
    neg         = pid[spc_pkg::PID_W-1];
    abs_pid     = neg ? $unsigned(-pid) : $unsigned(pid);
    mag_sh      = abs_pid[spc_pkg::PID_W-1:8];
    mag_clamped = (mag_sh > 28'(spc_pkg::COMPARE_MAX)) ? 12'(spc_pkg::COMPARE_MAX)
                                                        : mag_sh[11:0];
    mag_trim    = $signed({1'b0, mag_clamped}) - $signed({1'b0, flags2.trim});
    if (flags2.fault || flags2.idle) begin
      cmp = 12'd1;
    end else if (mag_trim < 13'sd1) begin
      cmp = 12'd1;
    end else begin
      cmp = mag_trim[11:0];
    end
    // a faulted item keeps the last phase
    dir = flags2.fault ? phase_bit : (neg ^ cfg.invert_direction);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      p_term <= p_prod;
      i_term <= i_prod >>> 7;
      d_term <= d_prod;
      flags1 <= q_job.flags;
    end
    if (adv2) begin
      pid <= {{3{p_term[32]}}, p_term} + {{4{i_term[31]}}, i_term}
           - {{2{d_term[33]}}, d_term};
      flags2 <= flags1;
    end
    if (v2 && adv3) begin
      res.pwm_compare <= cmp;
      res.direction   <= dir;
      res.fault_flag  <= flags2.fault;
      res.power_ok    <= flags2.power;
      res.motor_idle  <= flags2.idle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
      phase_bit <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= q_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        res.valid <= v2;
      end
      if (v2 && adv3) begin
        phase_bit <= dir;
      end
    end
  end

endmodule

[sv/servo_pid_current_limit.sv]
// servo position controller with current limiting, one control tick per item
// cmd channel: position error, current adc sample and three active-low fault pins
// res channel: pwm compare value, direction bit and fault / power / idle status
// cfg port: cfg_we with cfg_index and cfg_data writes one register per cycle;
//   indexes past the last register are ignored, write only while no item is in flight
// the front keeps all tick state (faults, idle timeout, current trim, integral)
//   and updates it in the cycle an item is taken, then queues the item
// a two-entry queue feeds the back, which multiplies the three gains, sums the
//   pid output and forms the compare value in a three-register pipeline
// a taken item is written into the queue, then passes the product, sum and output registers in that order
// throughput: one item per cycle while cmd.ready is high, set by the front state update
// a stalled receiver fills the back pipeline and then the queue; cmd.ready drops
//   only when the queue is full, and items are never dropped or reordered
// reset (rst, synchronous) restores register defaults, clears fault and idle
//   state, sets power_ok and empties queue and pipeline
module servo_pid_current_limit (
  input  logic                             clk,
  input  logic                             rst,
  spc_cmd_if.sink                          cmd,
  spc_res_if.source                        res,
  input  logic                             cfg_we,
  input  logic [spc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spc_pkg::cfg_t cfg;
  spc_pkg::job_t push_job;
  spc_pkg::job_t q_job;
  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p           <= 16'd2500;
      cfg.gain_i           <= '0;
      cfg.gain_d           <= '0;
      cfg.sense_limit      <= 8'd255;
      cfg.invert_direction <= 1'b0;
      cfg.follow_limit     <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spc_pkg::REG_GAIN_P:           cfg.gain_p           <= cfg_data;
        spc_pkg::REG_GAIN_I:           cfg.gain_i           <= cfg_data;
        spc_pkg::REG_GAIN_D:           cfg.gain_d           <= cfg_data;
        spc_pkg::REG_SENSE_LIMIT:      cfg.sense_limit      <= cfg_data[7:0];
        spc_pkg::REG_INVERT_DIRECTION: cfg.invert_direction <= cfg_data[0];
        spc_pkg::REG_FOLLOW_LIMIT:     cfg.follow_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  spc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  spc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  spc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .res     (res)
  );

endmodule
